FILE: design/slws_pkg.sv
// Shared types, codes and helpers for the status LED wink sequencer.
// No dependencies; imported by every other design file.
package slws_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int DUR_WIDTH   = 16;
   localparam int FLASH_WIDTH = 3;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam logic [31:0] TMAX_EXT = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

   // actions carried by one request beat
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_SET   = 2'd1;
   localparam logic [1:0] ACT_IDENT = 2'd2;

   // LED modes
   localparam logic [2:0] MODE_OFF         = 3'd0;
   localparam logic [2:0] MODE_CONNECTED   = 3'd1;
   localparam logic [2:0] MODE_ADVERTISING = 3'd2;
   localparam logic [2:0] MODE_STALE       = 3'd3;
   localparam logic [2:0] MODE_DROPPED     = 3'd4;

   // drive colours, bit 0 red, bit 1 green, bit 2 blue
   localparam logic [2:0] RGB_NONE   = 3'b000;
   localparam logic [2:0] RGB_RED    = 3'b001;
   localparam logic [2:0] RGB_YELLOW = 3'b011;
   localparam logic [2:0] RGB_BLUE   = 3'b100;
   localparam logic [2:0] RGB_WHITE  = 3'b111;

   // register indexes
   localparam logic [2:0] REG_WINK       = 3'd0;
   localparam logic [2:0] REG_IDENT_ON   = 3'd1;
   localparam logic [2:0] REG_IDENT_OFF  = 3'd2;
   localparam logic [2:0] REG_IDLE_GAP   = 3'd3;
   localparam logic [2:0] REG_DROP_FAST  = 3'd4;
   localparam logic [2:0] REG_DROP_SLOW  = 3'd5;
   localparam logic [2:0] REG_INSIST     = 3'd6;
   localparam logic [2:0] REG_FLASHES    = 3'd7;

   // register reset values
   localparam logic [DUR_WIDTH-1:0]   RST_WINK      = DUR_WIDTH'(20);
   localparam logic [DUR_WIDTH-1:0]   RST_IDENT_ON  = DUR_WIDTH'(60);
   localparam logic [DUR_WIDTH-1:0]   RST_IDENT_OFF = DUR_WIDTH'(120);
   localparam logic [DUR_WIDTH-1:0]   RST_IDLE_GAP  = DUR_WIDTH'(2000);
   localparam logic [DUR_WIDTH-1:0]   RST_DROP_FAST = DUR_WIDTH'(1000);
   localparam logic [DUR_WIDTH-1:0]   RST_DROP_SLOW = DUR_WIDTH'(3000);
   localparam logic [DUR_WIDTH-1:0]   RST_INSIST    = DUR_WIDTH'(60000);
   localparam logic [FLASH_WIDTH-1:0] RST_FLASHES   = FLASH_WIDTH'(3);

   typedef struct packed {
      logic [DUR_WIDTH-1:0]   wink_ms;
      logic [DUR_WIDTH-1:0]   ident_on_ms;
      logic [DUR_WIDTH-1:0]   ident_off_ms;
      logic [DUR_WIDTH-1:0]   idle_gap_ms;
      logic [DUR_WIDTH-1:0]   drop_fast_gap_ms;
      logic [DUR_WIDTH-1:0]   drop_slow_gap_ms;
      logic [DUR_WIDTH-1:0]   insist_window_ms;
      logic [FLASH_WIDTH-1:0] ident_flashes;
   } cfg_type;

   // Load a duration into the step timer: zero counts as one, clip to the timer range.
   function automatic logic [TIMER_WIDTH-1:0] dur_load(input logic [DUR_WIDTH-1:0] ms);
      logic [31:0] v;
      v = 32'(ms);
      if (v == 32'd0) begin
         v = 32'd1;
      end
      if (v > TMAX_EXT) begin
         v = TMAX_EXT;
      end
      return v[TIMER_WIDTH-1:0];
   endfunction

endpackage

FILE: design/slws_csr.sv
// APB-style register file for the wink sequencer durations and flash count.
// Depends on slws_pkg.
module slws_csr
   import slws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   logic [2:0]  idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_AW-1:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WINK:      cfg_in.wink_ms          = pwdata[DUR_WIDTH-1:0];
            REG_IDENT_ON:  cfg_in.ident_on_ms      = pwdata[DUR_WIDTH-1:0];
            REG_IDENT_OFF: cfg_in.ident_off_ms     = pwdata[DUR_WIDTH-1:0];
            REG_IDLE_GAP:  cfg_in.idle_gap_ms      = pwdata[DUR_WIDTH-1:0];
            REG_DROP_FAST: cfg_in.drop_fast_gap_ms = pwdata[DUR_WIDTH-1:0];
            REG_DROP_SLOW: cfg_in.drop_slow_gap_ms = pwdata[DUR_WIDTH-1:0];
            REG_INSIST:    cfg_in.insist_window_ms = pwdata[DUR_WIDTH-1:0];
            REG_FLASHES:   cfg_in.ident_flashes    = pwdata[FLASH_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_WINK:      prdata = CSR_DW'(cfg_ff.wink_ms);
         REG_IDENT_ON:  prdata = CSR_DW'(cfg_ff.ident_on_ms);
         REG_IDENT_OFF: prdata = CSR_DW'(cfg_ff.ident_off_ms);
         REG_IDLE_GAP:  prdata = CSR_DW'(cfg_ff.idle_gap_ms);
         REG_DROP_FAST: prdata = CSR_DW'(cfg_ff.drop_fast_gap_ms);
         REG_DROP_SLOW: prdata = CSR_DW'(cfg_ff.drop_slow_gap_ms);
         REG_INSIST:    prdata = CSR_DW'(cfg_ff.insist_window_ms);
         REG_FLASHES:   prdata = CSR_DW'(cfg_ff.ident_flashes);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wink_ms          <= RST_WINK;
         cfg_ff.ident_on_ms      <= RST_IDENT_ON;
         cfg_ff.ident_off_ms     <= RST_IDENT_OFF;
         cfg_ff.idle_gap_ms      <= RST_IDLE_GAP;
         cfg_ff.drop_fast_gap_ms <= RST_DROP_FAST;
         cfg_ff.drop_slow_gap_ms <= RST_DROP_SLOW;
         cfg_ff.insist_window_ms <= RST_INSIST;
         cfg_ff.ident_flashes    <= RST_FLASHES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/slws_core.sv
// Sequencer state and the single-pass step logic for one request beat.
// Depends on slws_pkg.
module slws_core
   import slws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [1:0] action,
   input  logic [2:0] mode_code,
   input  cfg_type    cfg,
   output logic [2:0] rgb_next
);

   logic [2:0]             cur_mode_ff,      cur_mode_in;
   logic                   is_lit_ff,        is_lit_in;
   logic [FLASH_WIDTH-1:0] flashes_left_ff,  flashes_left_in;
   logic                   step_pending_ff,  step_pending_in;
   logic [TIMER_WIDTH-1:0] ms_to_step_ff,    ms_to_step_in;
   logic [TIMER_WIDTH-1:0] ms_since_drop_ff, ms_since_drop_in;
   logic [2:0]             rgb_ff,           rgb_in;

   logic                   run;
   logic                   in_window;
   logic [TIMER_WIDTH-1:0] tick_left;

   always_comb begin
      cur_mode_in      = cur_mode_ff;
      is_lit_in        = is_lit_ff;
      flashes_left_in  = flashes_left_ff;
      step_pending_in  = step_pending_ff;
      ms_to_step_in    = ms_to_step_ff;
      ms_since_drop_in = ms_since_drop_ff;
      rgb_in           = rgb_ff;
      run              = 1'b0;
      tick_left        = ms_to_step_ff;
      if (ms_to_step_ff != '0) begin
         tick_left = ms_to_step_ff - TIMER_WIDTH'(1);
      end

      // decode the beat
      unique case (action)
         ACT_TICK: begin
            if (ms_since_drop_ff != '1) begin
               ms_since_drop_in = ms_since_drop_ff + TIMER_WIDTH'(1);
            end
            if (step_pending_ff) begin
               ms_to_step_in = tick_left;
               run           = (tick_left == '0);
            end
         end
         ACT_SET: begin
            if (mode_code <= MODE_DROPPED &&
                !(mode_code == cur_mode_ff && mode_code != MODE_DROPPED)) begin
               cur_mode_in = mode_code;
               if (mode_code == MODE_DROPPED) begin
                  ms_since_drop_in = '0;
               end
               rgb_in    = RGB_NONE;
               is_lit_in = 1'b0;
               run       = 1'b1;
            end
         end
         ACT_IDENT: begin
            flashes_left_in = cfg.ident_flashes;
            rgb_in          = RGB_NONE;
            is_lit_in       = 1'b0;
            run             = 1'b1;
         end
         default: begin
         end
      endcase

      in_window = 32'(ms_since_drop_in) < 32'(cfg.insist_window_ms);

      // wink step
      if (run) begin
         step_pending_in = 1'b0;
         if (is_lit_in) begin
            rgb_in    = RGB_NONE;
            is_lit_in = 1'b0;
            if (flashes_left_in != '0) begin
               flashes_left_in = flashes_left_in - FLASH_WIDTH'(1);
               ms_to_step_in   = dur_load(cfg.ident_off_ms);
               step_pending_in = 1'b1;
            end else begin
               case (cur_mode_in) inside
                  MODE_ADVERTISING, MODE_STALE: begin
                     ms_to_step_in   = dur_load(cfg.idle_gap_ms);
                     step_pending_in = 1'b1;
                  end
                  MODE_DROPPED: begin
                     ms_to_step_in   = in_window ? dur_load(cfg.drop_fast_gap_ms)
                                                 : dur_load(cfg.drop_slow_gap_ms);
                     step_pending_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end else if (flashes_left_in != '0) begin
            rgb_in          = RGB_WHITE;
            is_lit_in       = 1'b1;
            ms_to_step_in   = dur_load(cfg.ident_on_ms);
            step_pending_in = 1'b1;
         end else begin
            case (cur_mode_in)
               MODE_ADVERTISING: rgb_in = RGB_BLUE;
               MODE_DROPPED:     rgb_in = RGB_RED;
               MODE_STALE:       rgb_in = RGB_YELLOW;
               default:          rgb_in = rgb_in;
            endcase
            if (cur_mode_in == MODE_ADVERTISING || cur_mode_in == MODE_DROPPED ||
                cur_mode_in == MODE_STALE) begin
               is_lit_in       = 1'b1;
               ms_to_step_in   = dur_load(cfg.wink_ms);
               step_pending_in = 1'b1;
            end
         end
      end
   end

   assign rgb_next = rgb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff      <= MODE_OFF;
         is_lit_ff        <= 1'b0;
         flashes_left_ff  <= '0;
         step_pending_ff  <= 1'b0;
         ms_to_step_ff    <= '0;
         ms_since_drop_ff <= '0;
         rgb_ff           <= RGB_NONE;
      end else if (step_en) begin
         cur_mode_ff      <= cur_mode_in;
         is_lit_ff        <= is_lit_in;
         flashes_left_ff  <= flashes_left_in;
         step_pending_ff  <= step_pending_in;
         ms_to_step_ff    <= ms_to_step_in;
         ms_since_drop_ff <= ms_since_drop_in;
         rgb_ff           <= rgb_in;
      end
   end

endmodule

FILE: design/status_led_wink_sequencer_top.sv
// Top level of the status LED wink sequencer: request/result registers around the core.
// Depends on slws_pkg, slws_csr and slws_core.
//
// Each request beat is a 1 ms tick, a mode change or an identify request, and
// yields exactly one result beat: the red/green/blue drive after that beat.
// The block takes one request per clock cycle for as long as results are
// taken; a request is captured in an input register, passes the step logic
// once the result register is free or being drained, and lands in the
// result register. The result register and the input register together
// decouple the two sides, so a request is still accepted while a finished
// result waits. Timing registers are written through the APB-style port at
// byte address 4*index and must only be changed while no request is in
// flight.
module status_led_wink_sequencer_top
   import slws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [2:0]        req_mode_code,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_red_on,
   output logic              rsp_green_on,
   output logic              rsp_blue_on,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type    cfg;
   logic       in_valid_ff,  in_valid_in;
   logic [1:0] in_action_ff;
   logic [2:0] in_mode_ff;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_rgb_ff;
   logic [2:0] rgb_next;
   logic       req_fire;
   logic       out_load;

   slws_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Advance the captured beat whenever the result register is free or being drained.
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;

   slws_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (out_load),
      .action    (in_action_ff),
      .mode_code (in_mode_ff),
      .cfg       (cfg),
      .rgb_next  (rgb_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: hold until the next beat moves in
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_action;
         in_mode_ff   <= req_mode_code;
      end
      if (out_load) begin
         out_rgb_ff <= rgb_next;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_red_on   = out_rgb_ff[0];
   assign rsp_green_on = out_rgb_ff[1];
   assign rsp_blue_on  = out_rgb_ff[2];

endmodule

FILE: design/slws_checker.sv
// Port-level checks for the status LED wink sequencer, bound to the top level.
// Depends on slws_pkg and status_led_wink_sequencer_top.
module slws_checker
   import slws_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_red_on,
   input logic rsp_green_on,
   input logic rsp_blue_on
);

   // an empty pipeline after reset: nothing shown, requests taken
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // a stalled result beat holds its colour
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_red_on) && $stable(rsp_green_on) && $stable(rsp_blue_on))
      else $error("stalled result beat changed");

   // only dark, red, yellow, blue or white can be driven
   a_green_needs_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_green_on |-> rsp_red_on)
      else $error("green lit without red");

   a_blue_colours: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blue_on |-> (rsp_red_on == rsp_green_on))
      else $error("blue lit with a mixed red/green drive");

endmodule

bind status_led_wink_sequencer_top slws_checker u_slws_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_red_on   (rsp_red_on),
   .rsp_green_on (rsp_green_on),
   .rsp_blue_on  (rsp_blue_on)
);

FILE: bench/status_led_wink_sequencer_top_tb.sv
// Self-checking bench for status_led_wink_sequencer_top: random and directed beats, APB set-up.
// Depends on slws_pkg and the design under design/; needs nothing else.
module status_led_wink_sequencer_top_tb;
   import slws_pkg::*;

   // action code with no meaning; the block must report the drive unchanged
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int WINDOW_TICKS = 64;

   // Tracks what the LED drive must be after each request beat and checks the
   // result beats against that, oldest first.
   class wink_scoreboard;
      logic [DUR_WIDTH-1:0]   dur_ms [0:6];
      logic [FLASH_WIDTH-1:0] flash_count;
      logic [2:0]             mode_now;
      bit                     lit;
      logic [2:0]             flashes_left;
      bit                     step_armed;
      logic [TIMER_WIDTH-1:0] ms_left;
      logic [TIMER_WIDTH-1:0] ms_since_drop;
      logic [2:0]             rgb;
      logic [2:0]             drive_q [$];
      int                     errors;

      function new();
         dur_ms[REG_WINK]      = RST_WINK;
         dur_ms[REG_IDENT_ON]  = RST_IDENT_ON;
         dur_ms[REG_IDENT_OFF] = RST_IDENT_OFF;
         dur_ms[REG_IDLE_GAP]  = RST_IDLE_GAP;
         dur_ms[REG_DROP_FAST] = RST_DROP_FAST;
         dur_ms[REG_DROP_SLOW] = RST_DROP_SLOW;
         dur_ms[REG_INSIST]    = RST_INSIST;
         flash_count   = RST_FLASHES;
         mode_now      = MODE_OFF;
         lit           = 1'b0;
         flashes_left  = '0;
         step_armed    = 1'b0;
         ms_left       = '0;
         ms_since_drop = '0;
         rgb           = RGB_NONE;
         errors        = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         if (idx == REG_FLASHES)
            flash_count = val[FLASH_WIDTH-1:0];
         else
            dur_ms[idx] = val[DUR_WIDTH-1:0];
      endfunction

      // load the step timer; zero counts as one, clip to what the timer holds
      function void arm(logic [DUR_WIDTH-1:0] ms);
         logic [31:0] v;
         v = 32'(ms);
         if (v == 32'd0) v = 32'd1;
         if (v > TMAX_EXT) v = TMAX_EXT;
         ms_left    = v[TIMER_WIDTH-1:0];
         step_armed = 1'b1;
      endfunction

      function void douse();
         rgb = RGB_NONE;
         lit = 1'b0;
      endfunction

      function void wink_step();
         logic [2:0] colour;
         colour     = RGB_NONE;
         step_armed = 1'b0;
         if (lit) begin
            douse();
            if (flashes_left != '0) begin
               flashes_left = flashes_left - 3'd1;
               arm(dur_ms[REG_IDENT_OFF]);
            end else if (mode_now == MODE_ADVERTISING || mode_now == MODE_STALE) begin
               arm(dur_ms[REG_IDLE_GAP]);
            end else if (mode_now == MODE_DROPPED) begin
               if (32'(ms_since_drop) < 32'(dur_ms[REG_INSIST]))
                  arm(dur_ms[REG_DROP_FAST]);
               else
                  arm(dur_ms[REG_DROP_SLOW]);
            end
         end else if (flashes_left != '0) begin
            rgb = RGB_WHITE;
            lit = 1'b1;
            arm(dur_ms[REG_IDENT_ON]);
         end else begin
            case (mode_now)
               MODE_ADVERTISING: colour = RGB_BLUE;
               MODE_STALE:       colour = RGB_YELLOW;
               MODE_DROPPED:     colour = RGB_RED;
               default:          colour = RGB_NONE;
            endcase
            if (colour != RGB_NONE) begin
               rgb = colour;
               lit = 1'b1;
               arm(dur_ms[REG_WINK]);
            end
         end
      endfunction

      function void note_request(logic [1:0] act, logic [2:0] m);
         case (act)
            ACT_TICK: begin
               if (ms_since_drop != '1) ms_since_drop = ms_since_drop + 1'b1;
               if (step_armed) begin
                  if (ms_left != '0) ms_left = ms_left - 1'b1;
                  if (ms_left == '0) wink_step();
               end
            end
            ACT_SET: begin
               if (m <= MODE_DROPPED && !(m == mode_now && m != MODE_DROPPED)) begin
                  mode_now = m;
                  if (m == MODE_DROPPED) ms_since_drop = '0;
                  douse();
                  wink_step();
               end
            end
            ACT_IDENT: begin
               flashes_left = flash_count;
               douse();
               wink_step();
            end
            default: ;
         endcase
         drive_q.push_back(rgb);
      endfunction

      function void check_drive(logic red, logic green, logic blue);
         logic [2:0] want;
         if (drive_q.size() == 0) begin
            $error("result beat with nothing expected: red %0b green %0b blue %0b",
                   red, green, blue);
            errors++;
            return;
         end
         want = drive_q.pop_front();
         if (red !== want[0]) begin
            $error("red_on: expected %0b, got %0b", want[0], red);
            errors++;
         end
         if (green !== want[1]) begin
            $error("green_on: expected %0b, got %0b", want[1], green);
            errors++;
         end
         if (blue !== want[2]) begin
            $error("blue_on: expected %0b, got %0b", want[2], blue);
            errors++;
         end
      endfunction

      function int outstanding();
         return drive_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_action;
   logic [2:0]        req_mode_code;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_red_on;
   logic              rsp_green_on;
   logic              rsp_blue_on;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   wink_scoreboard board = new();

   // idling switches, set per phase by the stimulus process
   bit src_idle_en = 1'b1;
   bit snk_idle_en = 1'b1;
   // one-off long hold-off for the result side, consumed by the sink process
   int rsp_hold    = 0;
   int cycle_count = 0;

   status_led_wink_sequencer_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_mode_code (req_mode_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_on    (rsp_red_on),
      .rsp_green_on  (rsp_green_on),
      .rsp_blue_on   (rsp_blue_on),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Guard against a hang: give up well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one request beat. Drive at the falling edge, hold valid and payload
   // until a rising edge sees ready, then log the beat with the scoreboard.
   // Reads straight after the rising edge see the values the block sampled.
   task automatic send_request(logic [1:0] act, logic [2:0] m);
      int gap;
      gap = src_idle_en ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_mode_code <= m;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(act, m);
   endtask

   // Drop valid and wait until every expected result beat has come back, then
   // keep idling so the pipeline is truly empty.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle held until pready.
   task automatic write_register(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      board.write_reg(idx, val);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly short durations so winks cycle often; now and then the two
   // extremes. Upper bits carry rubbish, which the register must ignore.
   function automatic logic [31:0] pick_duration(int top);
      int r;
      logic [15:0] d;
      r = $urandom_range(0, 19);
      if (r == 0)
         d = 16'd0;
      else if (r == 1)
         d = 16'hFFFF;
      else
         d = 16'($urandom_range(1, top));
      return {16'($urandom), d};
   endfunction

   // Phase 0 takes every duration at zero with the most flashes, phase 5 every
   // duration at its maximum with a single flash; the rest are random.
   task automatic program_phase(int ph);
      logic [31:0] v;
      int i;
      for (i = 0; i < 8; i++) begin
         if (i == REG_FLASHES)
            v = (ph == 0) ? 32'd7 : (ph == 5) ? 32'd1 : $urandom;
         else if (ph == 0)
            v = 32'hFFFF_0000;
         else if (ph == 5)
            v = 32'h0000_FFFF;
         else if (i == REG_INSIST)
            v = pick_duration(40);
         else
            v = pick_duration(12);
         write_register(3'(i), v);
      end
   endtask

   // Random traffic as real use looks: a command, then a run of ticks long
   // enough for winks, gaps and the insist window to play out.
   task automatic send_random_traffic(int count);
      int left;
      int run;
      int r;
      logic [1:0] act;
      logic [2:0] m;
      left = count;
      while (left > 0) begin
         r = $urandom_range(0, 99);
         m = 3'($urandom);
         if (r < 60) begin
            act = ACT_SET;
            if ($urandom_range(0, 7) != 0) m = 3'($urandom_range(0, 4));
         end else if (r < 88) begin
            act = ACT_IDENT;
         end else if (r < 94) begin
            act = ACT_UNKNOWN;
         end else begin
            act = ACT_TICK;
         end
         send_request(act, m);
         left--;
         run = $urandom_range(0, 24);
         while (run > 0 && left > 0) begin
            send_request(ACT_TICK, 3'($urandom));
            run--;
            left--;
         end
      end
   endtask

   // Result side: draw a stall per beat, hold ready high until a beat lands,
   // then check it. A pending long hold-off replaces one drawn stall.
   initial begin : result_sink
      int gap;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = snk_idle_en ? $urandom_range(0, 17) : 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         board.check_drive(rsp_red_on, rsp_green_on, rsp_blue_on);
      end
   end

   initial begin : stimulus
      int ph;
      int i;
      req_valid     = 1'b0;
      req_action    = ACT_TICK;
      req_mode_code = MODE_OFF;
      rsp_ready     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      reset         = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset timings. Same mode twice, identify over a mode, the
      // unknown action and unknown mode codes, dropped twice, the dark modes.
      send_request(ACT_SET, MODE_ADVERTISING);
      send_request(ACT_TICK, MODE_OFF);
      send_request(ACT_SET, MODE_ADVERTISING);
      send_request(ACT_IDENT, MODE_OFF);
      send_request(ACT_UNKNOWN, 3'd7);
      send_request(ACT_SET, 3'd5);
      send_request(ACT_SET, 3'd7);
      send_request(ACT_SET, MODE_STALE);
      send_request(ACT_SET, MODE_DROPPED);
      send_request(ACT_SET, MODE_DROPPED);
      send_request(ACT_SET, MODE_CONNECTED);
      send_request(ACT_SET, MODE_OFF);

      // Short timings, zero durations and zero flashes; walk a drop past the
      // insist window so the gap switches from fast to slow.
      wait_for_drain();
      write_register(REG_WINK,      32'd0);
      write_register(REG_IDENT_ON,  32'd1);
      write_register(REG_IDENT_OFF, 32'd0);
      write_register(REG_IDLE_GAP,  32'd1);
      write_register(REG_DROP_FAST, 32'd1);
      write_register(REG_DROP_SLOW, 32'd2);
      write_register(REG_INSIST,    32'd2);
      write_register(REG_FLASHES,   32'd0);
      send_request(ACT_IDENT, MODE_OFF);
      send_request(ACT_SET, MODE_DROPPED);
      for (i = 0; i < 6; i++) send_request(ACT_TICK, MODE_OFF);
      send_request(ACT_SET, MODE_STALE);
      for (i = 0; i < 3; i++) send_request(ACT_TICK, MODE_OFF);
      send_request(ACT_SET, MODE_OFF);

      // Random phases, each with fresh timings. Vary which side idles so that
      // some stretches run flat out; halfway through, pause until drained.
      for (ph = 0; ph < 6; ph++) begin
         wait_for_drain();
         program_phase(ph);
         src_idle_en = (ph % 3 != 2);
         snk_idle_en = (ph % 3 != 1);
         if (ph == 1) begin
            // hold the result side off for a long stretch while beats keep
            // coming, so the block fills and stalls its request side
            src_idle_en = 1'b0;
            rsp_hold    = 90;
            send_random_traffic(150);
            src_idle_en = 1'b1;
         end else begin
            send_random_traffic(150);
         end
         wait_for_drain();
         send_random_traffic(150);
      end

      // Window at its maximum: red winks keep the fast gap for the whole run
      // of ticks, back to back on both sides.
      wait_for_drain();
      write_register(REG_WINK,      32'd1);
      write_register(REG_DROP_FAST, 32'd1);
      write_register(REG_DROP_SLOW, 32'd3);
      write_register(REG_INSIST,    32'h0000_FFFF);
      src_idle_en = 1'b0;
      snk_idle_en = 1'b0;
      send_request(ACT_SET, MODE_DROPPED);
      for (i = 0; i < WINDOW_TICKS; i++) send_request(ACT_TICK, 3'($urandom));

      wait_for_drain();
      repeat (8) @(negedge clock);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
design/slws_pkg.sv
design/slws_csr.sv
design/slws_core.sv
design/status_led_wink_sequencer_top.sv
design/slws_checker.sv
bench/status_led_wink_sequencer_top_tb.sv
